/* rtl/block_bitmap_allocator_core_assert.svh */
// ----------------------------------------------------------------------------
// Block bitmap allocator assertion macros
// Shared forms for the concurrent checks on the allocator ports.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Item types, operation and status codes, and default sizes.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int NUM_BLOCKS_DEF  = 640;
    localparam int WORD_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [9:0] RESERVED_RESET = 10'd33;

    localparam logic [2:0] OP_ALLOC  = 3'd0;
    localparam logic [2:0] OP_MARK   = 3'd1;
    localparam logic [2:0] OP_FREE   = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_FORMAT = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_USED  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Command fields are sized for the largest map the parameters allow.
    localparam int CMD_WORD_W = 10;
    localparam int CMD_BIT_W  = 6;

    typedef struct packed {
        logic [2:0] op;
        logic [9:0] block_number;
        logic [5:0] word_index;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  block_out;
        logic [15:0] map_word;
    } t_out;

    typedef struct packed {
        logic [2:0]            op;
        logic                  err;
        logic [CMD_WORD_W-1:0] word;
        logic [CMD_BIT_W-1:0]  bitsel;
    } t_cmd;

endpackage

/* rtl/block_bitmap_allocator_core.sv */
// An item waits in the command queue until the back end pops it, which it does
// only when idle and with room in the result queue, where its result is pushed.
// The back end takes no new item until done with the last: a read-modify-write
// of one map word in the bitmap RAM (read in IDLE, update and write in EXEC).
// Reset is synchronous and active low: it empties both queues, sets the
// reserved count to 33 and marks those blocks used through per-word valid bits.
// ----------------------------------------------------------------------------
// Block bitmap allocator
// First-fit free-block allocator over an occupancy bitmap kept in a RAM.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_core import bba_pkg::*; #(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  t_in        i_item,
    output logic       empty,
    input  logic       pop,
    output t_out       o_result,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [9:0] i_cfg_data
);

    logic [9:0] r_reserved;
    t_cmd       cmd_in;
    t_cmd       cmd_out;
    logic       cmd_empty;
    logic       cmd_pop;
    logic       res_full;
    logic       res_push;
    t_out       res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved <= RESERVED_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_reserved <= i_cfg_data;
        end
    end

    bba_front #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .WORD_BITS  (WORD_BITS)
    ) u_front (
        .i_item (i_item),
        .o_cmd  (cmd_in)
    );

    bba_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_out),
        .o_empty (cmd_empty)
    );

    bba_back #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .WORD_BITS  (WORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_reserved  (r_reserved),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    bba_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (o_result),
        .o_empty (empty)
    );

endmodule

/* rtl/bba_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 40
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bba_fifo.sv */
// ----------------------------------------------------------------------------
// Small queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module bba_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

/* rtl/bba_front.sv */
// ----------------------------------------------------------------------------
// Allocator front end
// Classifies an incoming item: range checks and block-to-word split.
// ----------------------------------------------------------------------------
module bba_front import bba_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  t_in  i_item,
    output t_cmd o_cmd
);

    localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP     = (1 << 16) / WORD_BITS;

    logic [31:0] prod;
    logic [31:0] q_est;
    logic [31:0] rem_est;
    logic [31:0] quot;
    logic [31:0] rem;

    // The reciprocal estimate is low by at most one, so one correction step
    // gives the exact quotient and remainder.
    always_comb begin
        prod    = 32'(i_item.block_number) * 32'(RECIP);
        q_est   = prod >> 16;
        rem_est = 32'(i_item.block_number) - q_est * 32'(WORD_BITS);
        if (rem_est >= 32'(WORD_BITS)) begin
            quot = q_est + 32'd1;
            rem  = rem_est - 32'(WORD_BITS);
        end else begin
            quot = q_est;
            rem  = rem_est;
        end
    end

    always_comb begin
        o_cmd.op     = i_item.op;
        o_cmd.err    = 1'b0;
        o_cmd.word   = quot[CMD_WORD_W-1:0];
        o_cmd.bitsel = rem[CMD_BIT_W-1:0];
        case (i_item.op)
            OP_ALLOC, OP_FORMAT: begin
                o_cmd.err = 1'b0;
            end
            OP_MARK, OP_FREE: begin
                o_cmd.err = (32'(i_item.block_number) >= 32'(NUM_BLOCKS));
            end
            OP_READ: begin
                o_cmd.err  = (32'(i_item.word_index) >= 32'(MAP_WORDS));
                o_cmd.word = CMD_WORD_W'(i_item.word_index);
            end
            default: begin
                o_cmd.err = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/bba_back.sv */
// ----------------------------------------------------------------------------
// Allocator back end
// Executes one command at a time: reads a map word, updates it, writes back.
// ----------------------------------------------------------------------------
module bba_back import bba_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [9:0] i_reserved,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_empty,
    output logic       o_cmd_pop,
    input  logic       i_res_full,
    output logic       o_res_push,
    output t_out       o_res
);

    localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
    localparam int RST_SAT   = (int'(RESERVED_RESET) > NUM_BLOCKS) ?
                               NUM_BLOCKS : int'(RESERVED_RESET);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Word w as left by a format that reserved the first n blocks.
    function automatic logic [WORD_BITS-1:0] fmt_word(input logic [WADDR_W-1:0] w,
                                                      input logic [CNT_W-1:0] n);
        logic [WORD_BITS-1:0] v;
        v = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            v[j] = ((32'(w) * 32'(WORD_BITS) + 32'(j)) < 32'(n));
        end
        return v;
    endfunction

    // Bits of word w that lie past the last block; they count as used.
    function automatic logic [WORD_BITS-1:0] pad_mask(input logic [WADDR_W-1:0] w);
        logic [WORD_BITS-1:0] v;
        v = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            v[j] = ((32'(w) * 32'(WORD_BITS) + 32'(j)) >= 32'(NUM_BLOCKS));
        end
        return v;
    endfunction

    function automatic logic [MAP_WORDS-1:0] fmt_full(input logic [CNT_W-1:0] n);
        logic [MAP_WORDS-1:0] v;
        logic [31:0]          top;
        v = '0;
        for (int w = 0; w < MAP_WORDS; w++) begin
            top  = 32'((w + 1) * WORD_BITS);
            if (top > 32'(NUM_BLOCKS)) begin
                top = 32'(NUM_BLOCKS);
            end
            v[w] = (top <= 32'(n));
        end
        return v;
    endfunction

    logic                 r_state;
    t_cmd                 r_cmd;
    logic [WADDR_W-1:0]   r_waddr;
    logic                 r_none;
    logic [MAP_WORDS-1:0] r_valid;
    logic [MAP_WORDS-1:0] r_full;
    logic [CNT_W-1:0]     r_fmt;

    logic [WADDR_W-1:0]   free_w;
    logic                 any_free;
    logic [WADDR_W-1:0]   rd_addr;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] base;
    logic [WORD_BITS-1:0] pad;
    logic [WORD_BITS-1:0] cur;
    logic [WORD_BITS-1:0] mask;
    logic [BIT_W-1:0]     zero_j;
    logic                 we;
    logic [WORD_BITS-1:0] wdata;
    logic [31:0]          blk_num;
    logic [63:0]          wide;
    logic [31:0]          sat32;
    logic [CNT_W-1:0]     sat;

    assign o_cmd_pop  = (r_state == ST_IDLE) && !i_cmd_empty && !i_res_full;
    assign o_res_push = (r_state == ST_EXEC);

    // Lowest word that still has a free block.
    always_comb begin
        any_free = 1'b0;
        free_w   = '0;
        for (int w = MAP_WORDS - 1; w >= 0; w--) begin
            if (!r_full[w]) begin
                any_free = 1'b1;
                free_w   = WADDR_W'(w);
            end
        end
    end

    assign rd_addr = (i_cmd.op == OP_ALLOC) ? free_w : i_cmd.word[WADDR_W-1:0];

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_waddr),
        .i_wdata (wdata),
        .i_re    (o_cmd_pop),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // A word not written since the last format reads as the format pattern.
    assign base = r_valid[r_waddr] ? rdata : fmt_word(r_waddr, r_fmt);
    assign pad  = pad_mask(r_waddr);
    assign cur  = base | pad;
    assign mask = WORD_BITS'(1) << r_cmd.bitsel[BIT_W-1:0];

    always_comb begin
        zero_j = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (!cur[j]) begin
                zero_j = BIT_W'(j);
            end
        end
    end

    assign blk_num = 32'(r_waddr) * 32'(WORD_BITS) + 32'(zero_j);
    assign wide    = 64'(base);
    assign sat32   = (32'(i_reserved) > 32'(NUM_BLOCKS)) ? 32'(NUM_BLOCKS)
                                                         : 32'(i_reserved);
    assign sat     = sat32[CNT_W-1:0];

    always_comb begin
        we               = 1'b0;
        wdata            = base;
        o_res.status     = ST_OK;
        o_res.block_out  = '0;
        o_res.map_word   = '0;
        if (r_cmd.err) begin
            o_res.status = ST_RANGE;
        end else begin
            case (r_cmd.op)
                OP_ALLOC: begin
                    if (r_none) begin
                        o_res.status = ST_FULL;
                    end else begin
                        we              = (r_state == ST_EXEC);
                        wdata           = base | (WORD_BITS'(1) << zero_j);
                        o_res.block_out = blk_num[9:0];
                    end
                end
                OP_MARK: begin
                    if ((base & mask) != '0) begin
                        o_res.status = ST_USED;
                    end else begin
                        we    = (r_state == ST_EXEC);
                        wdata = base | mask;
                    end
                end
                OP_FREE: begin
                    we    = (r_state == ST_EXEC);
                    wdata = base & ~mask;
                end
                OP_READ: begin
                    o_res.map_word = wide[15:0];
                end
                OP_FORMAT: begin
                    we = 1'b0;
                end
                default: begin
                    o_res.status = ST_RANGE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_fmt   <= CNT_W'(RST_SAT);
            r_full  <= fmt_full(CNT_W'(RST_SAT));
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_cmd_pop) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= ST_IDLE;
                    if (we) begin
                        r_valid[r_waddr] <= 1'b1;
                        r_full[r_waddr]  <= &(wdata | pad);
                    end
                    if (!r_cmd.err && r_cmd.op == OP_FORMAT) begin
                        r_valid <= '0;
                        r_fmt   <= sat;
                        r_full  <= fmt_full(sat);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd   <= i_cmd;
            r_waddr <= rd_addr;
            r_none  <= !any_free;
        end
    end

endmodule

/* rtl/bba_checker.sv */
// ----------------------------------------------------------------------------
// Allocator port checker
// Concurrent checks on the allocator ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "block_bitmap_allocator_core_assert.svh"

module bba_checker import bba_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic push,
    input logic full,
    input logic empty,
    input logic pop,
    input t_out o_result
);

    // A waiting result that is not taken stays in place.
    `BBA_ASSERT_NEXT(a_res_hold, (!empty && !pop), (!empty && $stable(o_result)), "result changed while waiting")

    // Only a successful allocate or read carries data in its result.
    `BBA_ASSERT_NOW(a_err_zero, (!empty && o_result.status != ST_OK), (o_result.block_out == 10'd0 && o_result.map_word == 16'd0), "failed item carries data")

    // An allocated block number and a map word never come together.
    `BBA_ASSERT_NOW(a_one_payload, (!empty && o_result.block_out != 10'd0), (o_result.map_word == 16'd0), "block and map word both set")

    // Leaving reset, the result queue is empty and the command queue is not full.
    `BBA_ASSERT_NOW(a_reset_clear, ($past(!i_rst_n)), (empty && !full), "queues not empty after reset")

endmodule

bind block_bitmap_allocator_core bba_checker u_bba_checker (.*);

/* bench/tb_block_bitmap_allocator_core.sv */
// ----------------------------------------------------------------------------
// Block bitmap allocator testbench
// Pushes allocate, mark, free, read and format commands through the allocator
// with random gaps and stalls on both sides. A local model of the occupancy
// map predicts every result, and each popped result is checked field by field.
// The reserved count is rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_block_bitmap_allocator_core import bba_pkg::*; ();

    // Opcodes the core does not define; they must come back as out of range.
    localparam logic [2:0] OP_RSVD_A = 3'd5;
    localparam logic [2:0] OP_RSVD_C = 3'd7;

    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 88;
    localparam int LONG_HOLD   = 80;

    class alloc_scoreboard;
        localparam int MAP_WORDS = (NUM_BLOCKS_DEF + WORD_BITS_DEF - 1) / WORD_BITS_DEF;

        logic [WORD_BITS_DEF-1:0] occ [MAP_WORDS];
        logic [9:0]               reserved;
        t_out                     expected_q [$];
        int                       errors;
        int                       checked;

        function new();
            reserved = RESERVED_RESET;
            errors   = 0;
            checked  = 0;
            format_map();
        endfunction

        task report(string msg);
            // Keep the log readable if the core is badly broken.
            if (errors < 200) begin
                $display("ERROR @%0t: %s", $realtime, msg);
            end
            errors++;
        endtask

        function void format_map();
            int n;
            n = (int'(reserved) > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(reserved);
            foreach (occ[w]) begin
                occ[w] = '0;
            end
            for (int b = 0; b < n; b++) begin
                occ[b / WORD_BITS_DEF][b % WORD_BITS_DEF] = 1'b1;
            end
        endfunction

        function void set_reserved(logic [9:0] v);
            reserved = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Apply one accepted command to the map and queue the result it gives.
        function void note_item(t_in it);
            t_out r;
            int   b;
            int   w;
            r = '0;
            r.status = ST_OK;
            b = int'(it.block_number);
            w = int'(it.word_index);
            case (it.op)
                OP_ALLOC: begin
                    r.status = ST_FULL;
                    for (int k = 0; k < NUM_BLOCKS_DEF; k++) begin
                        if (!occ[k / WORD_BITS_DEF][k % WORD_BITS_DEF]) begin
                            occ[k / WORD_BITS_DEF][k % WORD_BITS_DEF] = 1'b1;
                            r.status    = ST_OK;
                            r.block_out = 10'(k);
                            break;
                        end
                    end
                end
                OP_MARK: begin
                    if (b >= NUM_BLOCKS_DEF) begin
                        r.status = ST_RANGE;
                    end else if (occ[b / WORD_BITS_DEF][b % WORD_BITS_DEF]) begin
                        r.status = ST_USED;
                    end else begin
                        occ[b / WORD_BITS_DEF][b % WORD_BITS_DEF] = 1'b1;
                    end
                end
                OP_FREE: begin
                    if (b >= NUM_BLOCKS_DEF) begin
                        r.status = ST_RANGE;
                    end else begin
                        occ[b / WORD_BITS_DEF][b % WORD_BITS_DEF] = 1'b0;
                    end
                end
                OP_READ: begin
                    if (w >= MAP_WORDS) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.map_word = occ[w];
                    end
                end
                OP_FORMAT: begin
                    format_map();
                end
                default: begin
                    r.status = ST_RANGE;
                end
            endcase
            expected_q.push_back(r);
        endfunction

        task compare_field(string name, int got, int want);
            if (got != want) begin
                report($sformatf("result %0d %s: got %0d, expected %0d",
                                 checked, name, got, want));
            end
        endtask

        task check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", checked));
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", int'(got.status), int'(want.status));
            compare_field("block_out", int'(got.block_out), int'(want.block_out));
            compare_field("map_word", int'(got.map_word), int'(want.map_word));
            checked++;
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_in        item = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_out       result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [9:0] cfg_data = '0;

    alloc_scoreboard sb;

    bit quiet = 1'b0;
    bit hold_off_req = 1'b0;
    int stall_left = 0;

    block_bitmap_allocator_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .push       (push),
        .full       (full),
        .i_item     (item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (result),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    always @(negedge clk) begin
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = LONG_HOLD;
        end else if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18);
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            sb.check_result(result);
        end
    end

    task automatic send_item(t_in it);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            @(negedge clk);
            push <= 1'b0;
            repeat ($urandom_range(0, 17)) @(negedge clk);
        end
        @(negedge clk);
        push <= 1'b1;
        item <= it;
        forever begin
            @(posedge clk);
            if (!full) begin
                break;
            end
        end
        sb.note_item(it);
    endtask

    task automatic send_op(logic [2:0] op, int blk, int widx);
        t_in it;
        it.op           = op;
        it.block_number = 10'(blk);
        it.word_index   = 6'(widx);
        send_item(it);
    endtask

    // Mostly in-range commands weighted toward allocate and free, so the map
    // both fills up and fragments; a few out-of-range fields and bad opcodes.
    task automatic send_random_op();
        int   sel;
        t_in  it;
        sel = $urandom_range(0, 99);
        it.block_number = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(640, 1023))
                                                      : 10'($urandom_range(0, 639));
        it.word_index   = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63))
                                                      : 6'($urandom_range(0, 39));
        if (sel < 40) begin
            it.op = OP_ALLOC;
        end else if (sel < 55) begin
            it.op = OP_MARK;
        end else if (sel < 75) begin
            it.op = OP_FREE;
        end else if (sel < 92) begin
            it.op = OP_READ;
        end else if (sel < 95) begin
            it.op = OP_FORMAT;
        end else begin
            it.op = 3'($urandom_range(OP_RSVD_A, OP_RSVD_C));
        end
        send_item(it);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reserved(logic [9:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        forever begin
            @(posedge clk);
            if (cfg_ready) begin
                break;
            end
        end
        sb.set_reserved(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [9:0] rsv;
        sb = new();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: map as left by reset, with 33 reserved blocks.
        send_op(OP_READ, 0, 0);
        send_op(OP_READ, 0, 2);
        send_op(OP_READ, 0, 39);
        send_op(OP_READ, 0, 40);
        send_op(OP_READ, 0, 63);
        send_op(OP_ALLOC, 0, 0);
        send_op(OP_MARK, 33, 0);
        send_op(OP_MARK, 34, 0);
        send_op(OP_MARK, 639, 0);
        send_op(OP_MARK, 640, 0);
        send_op(OP_MARK, 1023, 63);
        send_op(OP_FREE, 0, 0);
        send_op(OP_ALLOC, 0, 0);
        send_op(OP_FREE, 500, 0);
        send_op(OP_FREE, 1023, 0);
        send_op(OP_FREE, 639, 0);
        send_op(OP_READ, 0, 39);
        send_op(OP_RSVD_A, 1023, 63);
        send_op(OP_RSVD_A + 3'd1, 1023, 63);
        send_op(OP_RSVD_C, 1023, 63);
        send_op(OP_FORMAT, 0, 0);
        send_op(OP_READ, 0, 2);
        send_op(OP_ALLOC, 0, 0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: rsv = 10'd640;
                1: rsv = 10'd0;
                2: rsv = 10'd1023;
                3: rsv = 10'($urandom_range(1, 639));
                4: rsv = 10'($urandom_range(560, 639));
                default: rsv = 10'd1;
            endcase
            write_reserved(rsv);
            if (ph == 1) begin
                hold_off_req = 1'b1;
            end
            if (ph == NUM_PHASES - 1) begin
                quiet = 1'b1;
            end
            send_op(OP_FORMAT, 0, 0);
            // With the whole map reserved, allocate must report the map full.
            if (ph == 0) begin
                send_op(OP_ALLOC, 0, 0);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_op();
            end
        end

        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (sb.errors == 0) begin
            $display("tb_block_bitmap_allocator_core: clean");
        end else begin
            $display("tb_block_bitmap_allocator_core: errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_block_bitmap_allocator_core: errors");
        $finish;
    end

endmodule
